// File: src/rrsd_pkg.sv
package rrsd_pkg;

  typedef enum logic [2:0] {
    KIND_ACCEPTED   = 3'd0,
    KIND_FULL       = 3'd1,
    KIND_BAD_CTX    = 3'd2,
    KIND_DISPATCHED = 3'd3,
    KIND_NONE       = 3'd4
  } kind_e;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_RUN     = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  context_id;
    logic [15:0] source_buffer;
    logic [31:0] source_offset;
    logic [15:0] dest_buffer;
    logic [31:0] dest_offset;
    logic [31:0] copy_length;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [1:0]  out_context;
    logic [15:0] out_source_buffer;
    logic [31:0] out_source_offset;
    logic [15:0] out_dest_buffer;
    logic [31:0] out_dest_offset;
    logic [31:0] out_length;
    logic        last;
    logic        any_pending;
  } out_word_t;

  // request as held in the store: src handle/offset, dst handle/offset, length
  typedef struct packed {
    logic [15:0] sb;
    logic [31:0] so;
    logic [15:0] db;
    logic [31:0] dof;
    logic [31:0] len;
  } req_t;

endpackage

// File: src/rrsd_if.sv
interface rrsd_in_if;
  logic               valid;
  logic               ready;
  rrsd_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rrsd_out_if;
  logic                valid;
  logic                ready;
  rrsd_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/rrsd_store.sv
module rrsd_store #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  rrsd_pkg::req_t   wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output rrsd_pkg::req_t   rdata_o
);
  rrsd_pkg::req_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: src/round_robin_snapshot_dispatcher.sv
// Round-robin snapshot dispatcher.
// Input channel in (word: opcode, context, request). Opcode enqueue appends
// the request to its context's FIFO and returns one word: accepted, full or
// bad context. Opcode run snapshots every active queue count and then emits
// one dispatched word per request, visiting active contexts in ascending order
// pass after pass until each snapshot is spent; an empty run yields a single
// nothing-pending word. The final word of each input has last set.
// Config: cfg_we_i/cfg_wdata_i write active_contexts (values above
// NUM_CONTEXTS act as NUM_CONTEXTS). Write it only while nothing is in flight.
// Timing: an enqueue word is in the output register the cycle after accept;
// with the receiver taking every word, one enqueue per cycle is accepted.
// A run snapshots at the accept edge, then works each dispatched request in
// order: SCAN picks a context and issues the store read, READ sees the read
// data land, OUT loads the word into the output register. An empty run loads
// its word from SCAN. Requests go one at a time; the next pick waits for OUT.
// Reset clears queue counts, heads and the output valid; the store itself is
// not cleared, the counts guard every read. If the receiver stalls, the
// output register holds and the sequencer waits; no word is dropped.
// One input is worked at a time; in.ready is high only when idle and the
// output register is free or draining.
module round_robin_snapshot_dispatcher #(
  parameter int unsigned NUM_CONTEXTS = 4,
  parameter int unsigned QUEUE_DEPTH  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  rrsd_in_if.sink     in_i,
  rrsd_out_if.source  out_o
);
  localparam int unsigned CtxW   = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int unsigned SlotW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned Depth  = NUM_CONTEXTS * QUEUE_DEPTH;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned NumW   = $clog2(NUM_CONTEXTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_READ = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [2:0]       active_q;
  logic [NumW-1:0]  n_eff;
  logic [CntW-1:0]  cnt_q [NUM_CONTEXTS];
  logic [CntW-1:0]  snap_q [NUM_CONTEXTS];
  logic [SlotW-1:0] head_q [NUM_CONTEXTS];
  logic [CtxW-1:0]  cur_q;          // context to visit next in the round
  logic [CtxW-1:0]  disp_q;         // context whose read is in flight
  rrsd_pkg::out_word_t obuf_q, obuf_d;
  logic             ovalid_q, ovalid_d;

  // store ports
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  rrsd_pkg::req_t   wdata, rdata;

  rrsd_store #(.Depth(Depth), .AddrW(AddrW)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  always_comb begin
    if (32'(active_q) > NUM_CONTEXTS) n_eff = NumW'(NUM_CONTEXTS);
    else n_eff = NumW'(active_q);
  end

  // pending across active queues, counting the one being dispatched as gone
  function automatic logic pend(input logic [CntW-1:0] c [NUM_CONTEXTS],
                                input logic [NumW-1:0] n,
                                input logic dec, input logic [CtxW-1:0] dc);
    logic p;
    p = 1'b0;
    for (int i = 0; i < NUM_CONTEXTS; i++) begin
      if (NumW'(i) < n) begin
        if (dec && CtxW'(i) == dc) p = p | (c[i] > CntW'(1));
        else p = p | (c[i] != '0);
      end
    end
    return p;
  endfunction

  // next context at or after cur with snapshot left, wrapping
  logic             found;
  logic [CtxW-1:0]  pick;
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int k = NUM_CONTEXTS - 1; k >= 0; k--) begin
      int unsigned j;
      j = 32'(cur_q) + 32'(k);
      if (j >= NUM_CONTEXTS) j = j - NUM_CONTEXTS;
      if (NumW'(j) < n_eff && snap_q[j] != '0 && cnt_q[j] != '0) begin
        found = 1'b1;
        pick  = CtxW'(j);
      end
    end
  end

  logic             more_after;   // any snapshot left besides the one in flight
  always_comb begin
    more_after = 1'b0;
    for (int i = 0; i < NUM_CONTEXTS; i++) begin
      if (NumW'(i) < n_eff && cnt_q[i] != '0) begin
        if (CtxW'(i) == disp_q)
          more_after |= (snap_q[i] > CntW'(1)) && (cnt_q[i] > CntW'(1));
        else more_after |= (snap_q[i] != '0);
      end
    end
  end

  logic in_fire, out_free;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !ovalid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign out_o.valid = ovalid_q;
  assign out_o.data  = obuf_q;

  logic [CtxW-1:0]  in_ctx;
  logic             ctx_ok, is_full;
  assign in_ctx  = CtxW'(in_i.data.context_id);
  assign ctx_ok  = 32'(in_i.data.context_id) < 32'(n_eff);
  assign is_full = cnt_q[in_ctx] >= CntW'(QUEUE_DEPTH);

  always_comb begin
    int unsigned wslot;
    // tail slot = head + count, wrapped once at the queue depth
    wslot = 32'(head_q[in_ctx]) + 32'(cnt_q[in_ctx]);
    if (wslot >= QUEUE_DEPTH) wslot = wslot - QUEUE_DEPTH;
    we    = in_fire && in_i.data.opcode == rrsd_pkg::OP_ENQUEUE && ctx_ok && !is_full;
    waddr = AddrW'(32'(in_ctx) * QUEUE_DEPTH + wslot);
    wdata = '{sb: in_i.data.source_buffer, so: in_i.data.source_offset,
              db: in_i.data.dest_buffer, dof: in_i.data.dest_offset,
              len: in_i.data.copy_length};
    raddr = AddrW'(32'(pick) * QUEUE_DEPTH + 32'(head_q[pick]));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire && in_i.data.opcode == rrsd_pkg::OP_RUN) state_d = ST_SCAN;
      ST_SCAN: if (out_free) state_d = found ? ST_READ : ST_IDLE;
      ST_READ: state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = more_after ? ST_SCAN : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // output register: drains on handshake, loads a new word when free
  always_comb begin
    ovalid_d = ovalid_q && !out_o.ready;
    obuf_d   = obuf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_i.data.opcode == rrsd_pkg::OP_ENQUEUE) begin
          ovalid_d = 1'b1;
          obuf_d   = '0;
          obuf_d.result_kind = !ctx_ok ? rrsd_pkg::KIND_BAD_CTX :
                               is_full ? rrsd_pkg::KIND_FULL : rrsd_pkg::KIND_ACCEPTED;
          obuf_d.out_context = in_i.data.context_id;
          obuf_d.last        = 1'b1;
          obuf_d.any_pending = pend(cnt_q, n_eff, 1'b0, '0) || we;
        end
      end
      ST_SCAN: begin
        if (out_free && !found) begin
          ovalid_d = 1'b1;
          obuf_d   = '0;
          obuf_d.result_kind = rrsd_pkg::KIND_NONE;
          obuf_d.last        = 1'b1;
          obuf_d.any_pending = pend(cnt_q, n_eff, 1'b0, '0);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          obuf_d.result_kind       = rrsd_pkg::KIND_DISPATCHED;
          obuf_d.out_context       = 2'(disp_q);
          obuf_d.out_source_buffer = rdata.sb;
          obuf_d.out_source_offset = rdata.so;
          obuf_d.out_dest_buffer   = rdata.db;
          obuf_d.out_dest_offset   = rdata.dof;
          obuf_d.out_length        = rdata.len;
          obuf_d.last              = !more_after;
          obuf_d.any_pending       = pend(cnt_q, n_eff, 1'b1, disp_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    obuf_q <= obuf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= '0;
      ovalid_q <= 1'b0;
      cur_q    <= '0;
      disp_q   <= '0;
      for (int i = 0; i < NUM_CONTEXTS; i++) begin
        cnt_q[i]  <= '0;
        snap_q[i] <= '0;
        head_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) active_q <= cfg_wdata_i;
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_i.data.opcode == rrsd_pkg::OP_RUN) begin
              cur_q <= '0;
              for (int i = 0; i < NUM_CONTEXTS; i++)
                snap_q[i] <= (NumW'(i) < n_eff) ? cnt_q[i] : '0;
            end else if (we) begin
              cnt_q[in_ctx] <= cnt_q[in_ctx] + CntW'(1);
            end
          end
        end
        ST_SCAN: begin
          if (out_free && found) disp_q <= pick;
        end
        ST_OUT: begin
          if (out_free) begin
            cnt_q[disp_q]  <= cnt_q[disp_q] - CntW'(1);
            snap_q[disp_q] <= snap_q[disp_q] - CntW'(1);
            head_q[disp_q] <= (32'(head_q[disp_q]) == QUEUE_DEPTH - 1) ? '0 :
                              head_q[disp_q] + SlotW'(1);
            cur_q <= (32'(disp_q) + 1 >= 32'(n_eff)) ? '0 : CtxW'(32'(disp_q) + 1);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: src/rrsd_checker.sv
module rrsd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rrsd_pkg::out_word_t out_data
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");

  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !(in_valid && in_ready))
    else $error("input taken while output stalled");

  a_kind_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.result_kind <= rrsd_pkg::KIND_NONE)
    else $error("bad result kind");

  a_enq_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.result_kind != rrsd_pkg::KIND_DISPATCHED |-> out_data.last)
    else $error("non-dispatch result without last");

  a_none_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.result_kind == rrsd_pkg::KIND_NONE |-> !out_data.any_pending)
    else $error("empty round with pending work");
endmodule

bind round_robin_snapshot_dispatcher rrsd_checker u_rrsd_checker (
  .clk_i, .rst_ni,
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_data(out_o.data)
);
